/* rtl/relational_gin_graph_inference_assert.svh */
// Assertion macros used by the checker file of the graph inference block.
`ifndef RELATIONAL_GIN_GRAPH_INFERENCE_ASSERT_SVH
`define RELATIONAL_GIN_GRAPH_INFERENCE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define RGIN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgin check failed");

// Check a consequence in the cycle after its antecedent.
`define RGIN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgin check failed");

`endif

/* rtl/rgin_pkg.sv */
// Constants, codes and saturation helpers of the graph inference block.
package rgin_pkg;

    localparam int HIDDEN         = 32;
    localparam int FEATURES       = 20;
    localparam int RELATIONS      = 3;
    localparam int MAX_NODE_COUNT = 256;
    localparam int MAX_EDGE_COUNT = 512;

    localparam int NODE_W = 8;
    localparam int HID_W  = 5;
    localparam int REL_W  = 2;
    localparam int EDGE_W = 9;
    localparam int ROW_W  = 9;
    localparam int NCNT_W = 9;
    localparam int ECNT_W = 10;
    localparam int ACC_W  = 56;
    localparam int POOL_W = 48;
    localparam int DIVD_W = 40;
    localparam int EREC_W = 2 * NODE_W + REL_W;

    // Item kinds
    localparam logic [3:0] FN_IN_W   = 4'd0;
    localparam logic [3:0] FN_IN_B   = 4'd1;
    localparam logic [3:0] FN_REL_W  = 4'd2;
    localparam logic [3:0] FN_MLP_W  = 4'd3;
    localparam logic [3:0] FN_MLP_B  = 4'd4;
    localparam logic [3:0] FN_OUT_W  = 4'd5;
    localparam logic [3:0] FN_FEAT   = 4'd6;
    localparam logic [3:0] FN_EDGE   = 4'd7;
    localparam logic [3:0] FN_RUN    = 4'd8;

    // Result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_EPS  = 1'b0;
    localparam logic CFG_BIAS = 1'b1;

    // Clip an accumulator to the signed 32-bit range
    function automatic logic [31:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] res;
        if (v > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}}))
            res = {1'b0, {31{1'b1}}};
        else if (v < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}))
            res = {1'b1, {31{1'b0}}};
        else
            res = v[31:0];
        return res;
    endfunction

    // Flag an accumulator that lies outside the signed 32-bit range
    function automatic logic f_clips(input logic signed [ACC_W-1:0] v);
        return (v > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}})) ||
               (v < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}));
    endfunction

endpackage

/* rtl/rgin_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module rgin_ram #(
    parameter int W = 32,
    parameter int A = 5
) (
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [A-1:0] i_waddr,
    input  logic [W-1:0] i_wdata,
    input  logic [A-1:0] i_raddr,
    output logic [W-1:0] o_rdata
);

    logic [W-1:0] r_mem [2**A];
    logic [W-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rgin_div.sv */
// Restoring divider, one quotient bit per cycle, for the pooled mean.
module rgin_div
    import rgin_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [NCNT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [31:0]       o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [NCNT_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_q;
    logic [NCNT_W:0]   w_sh;
    logic              w_ge;
    logic [NCNT_W:0]   w_diff;

    // Shift in the next dividend bit and try the subtraction
    assign w_sh   = {r_rem, r_q[DIVD_W-1]};
    assign w_ge   = w_sh >= {1'b0, i_divisor};
    assign w_diff = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[NCNT_W-1:0] : w_sh[NCNT_W-1:0];
                r_q   <= {r_q[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[31:0];

endmodule

/* rtl/relational_gin_graph_inference.sv */
// Top level of the relational graph isomorphism network inference engine.
//
// Usage: items arrive on the s_axis channel; tuser carries the item kind
// (weight, bias, feature and edge loads, or run). A load writes one entry of
// the on-chip tables; it gives no result. A run item evaluates the loaded
// graph and returns one beat on m_axis: tdata holds the Q16.16 prediction,
// tuser the status (ok, empty graph, saturation). Configuration (eps, output
// bias) is to be written on the cfg channel while idle; the block itself does
// not enforce this. A run walks all state through one shared 33x33 multiplier;
// each product passes through a read, a multiply and an accumulate step. The
// mean divider runs once per hidden column. An empty graph goes straight to
// the output register with a zero prediction. The input stays stalled during
// a run. A finished result waits in the output register while the receiver
// stalls; loads are still taken then, a following run holds its result until
// that beat is taken. Reset clears the state, the output valid and the
// configuration registers; table contents are undefined until loaded.
module relational_gin_graph_inference
    import rgin_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_index, col_index, relation, value, edge_source, edge_target,
    // node_count, edge_count (from bit 0 up), zero fill to 88 bits
    input  logic [87:0] s_axis_tdata,
    // func
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // prediction
    output logic [31:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_P_BIAS, S_P_INIT, S_P_RD, S_P_MUL, S_P_ACC, S_P_SAT, S_P_SELF, S_P_SEED,
        S_E_RD, S_E_CHK, S_E_MRD, S_E_MINIT, S_E_WRD, S_E_MUL, S_E_ACC, S_E_WR,
        S_M_BIAS, S_M_INIT, S_M_RD, S_M_MUL, S_M_ACC, S_M_WR,
        S_O_RD, S_O_DIV, S_O_WAIT, S_O_MUL, S_O_ACC, S_O_FIN, S_OUT
    } t_state;

    t_state r_state;

    // Input fields
    logic [ROW_W-1:0]  w_row;
    logic [HID_W-1:0]  w_col;
    logic [REL_W-1:0]  w_rel;
    logic [31:0]       w_value;
    logic [NODE_W-1:0] w_src;
    logic [NODE_W-1:0] w_dst;
    logic [NCNT_W-1:0] w_ncnt;
    logic [ECNT_W-1:0] w_ecnt;
    logic [3:0]        w_func;
    logic              w_in_acc;

    assign w_row    = s_axis_tdata[8:0];
    assign w_col    = s_axis_tdata[13:9];
    assign w_rel    = s_axis_tdata[15:14];
    assign w_value  = s_axis_tdata[47:16];
    assign w_src    = s_axis_tdata[55:48];
    assign w_dst    = s_axis_tdata[63:56];
    assign w_ncnt   = s_axis_tdata[72:64];
    assign w_ecnt   = s_axis_tdata[82:73];
    assign w_func   = s_axis_tuser;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Configuration and run registers
    logic [17:0]              r_eps;
    logic [31:0]              r_obias;
    logic [NCNT_W-1:0]        r_ncnt;
    logic [ECNT_W-1:0]        r_ecnt;
    logic [NODE_W-1:0]        r_n;
    logic [HID_W-1:0]         r_j;
    logic [HID_W-1:0]         r_k;
    logic [EDGE_W-1:0]        r_e;
    logic [REL_W-1:0]         r_r;
    logic [NODE_W-1:0]        r_src;
    logic [NODE_W-1:0]        r_dst;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [65:0]       r_prod;
    logic [31:0]              r_val;
    logic [31:0]              r_ow;
    logic [POOL_W-1:0]        r_pool_old;
    logic                     r_flag;
    logic [31:0]              r_pred;
    logic [1:0]               r_status;
    logic                     r_m_tvalid;
    logic [31:0]              r_m_tdata;
    logic [1:0]               r_m_tuser;

    // Memory ports
    logic [31:0]       inw_q, inb_q, rw_q, mw_q, mb_q, ow_q, feat_q, proj_q, msg_q;
    logic [EREC_W-1:0] edge_q;
    logic [POOL_W-1:0] pool_q;
    logic              we_inw, we_inb, we_rw, we_mw, we_mb, we_ow, we_feat, we_edge;
    logic              we_proj, we_msg, we_pool;
    logic [12:0]       msg_waddr, msg_raddr;
    logic [31:0]       msg_wdata;
    logic [POOL_W-1:0] pool_wdata;

    // Datapath helpers
    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_relu;
    logic signed [18:0]      w_self;
    logic signed [32:0]      w_ma, w_mb;
    logic                    w_k_last_f, w_k_last_h, w_j_last, w_n_last, w_e_last, w_r_last;
    logic                    w_edge_ok;
    logic [NCNT_W-1:0]       w_ncnt_sat;
    logic [ECNT_W-1:0]       w_ecnt_sat;
    logic                    w_div_done;
    logic [31:0]             w_quot;
    logic                    w_out_free;

    assign w_term = {{(ACC_W-50){r_prod[65]}}, r_prod[65:16]};
    assign w_relu = r_acc[ACC_W-1] ? '0 : r_acc;
    assign w_self = 19'sd65536 + $signed({r_eps[17], r_eps});

    assign w_k_last_f = r_k == HID_W'(FEATURES - 1);
    assign w_k_last_h = r_k == HID_W'(HIDDEN - 1);
    assign w_j_last   = r_j == HID_W'(HIDDEN - 1);
    assign w_n_last   = NCNT_W'(r_n) == r_ncnt - NCNT_W'(1);
    assign w_e_last   = ECNT_W'(r_e) == r_ecnt - ECNT_W'(1);
    assign w_r_last   = r_r == REL_W'(RELATIONS - 1);
    assign w_edge_ok  = (edge_q[EREC_W-1:2*NODE_W] == r_r) &&
                        (NCNT_W'(edge_q[NODE_W-1:0]) < r_ncnt) &&
                        (NCNT_W'(edge_q[2*NODE_W-1:NODE_W]) < r_ncnt);
    assign w_ncnt_sat = (w_ncnt > NCNT_W'(MAX_NODE_COUNT)) ? NCNT_W'(MAX_NODE_COUNT) : w_ncnt;
    assign w_ecnt_sat = (w_ecnt > ECNT_W'(MAX_EDGE_COUNT)) ? ECNT_W'(MAX_EDGE_COUNT) : w_ecnt;
    assign w_out_free = !r_m_tvalid || m_axis_tready;

    // Load write enables, bounds checked
    always_comb begin
        we_inw  = w_in_acc && w_func == FN_IN_W && w_row < ROW_W'(HIDDEN)
                  && w_col < HID_W'(FEATURES);
        we_inb  = w_in_acc && w_func == FN_IN_B && w_row < ROW_W'(HIDDEN);
        we_rw   = w_in_acc && w_func == FN_REL_W && w_rel < REL_W'(RELATIONS)
                  && w_row < ROW_W'(HIDDEN);
        we_mw   = w_in_acc && w_func == FN_MLP_W && w_row < ROW_W'(HIDDEN);
        we_mb   = w_in_acc && w_func == FN_MLP_B && w_row < ROW_W'(HIDDEN);
        we_ow   = w_in_acc && w_func == FN_OUT_W && w_row < ROW_W'(HIDDEN);
        we_feat = w_in_acc && w_func == FN_FEAT
                  && NCNT_W'(w_row) < NCNT_W'(MAX_NODE_COUNT)
                  && w_col < HID_W'(FEATURES);
        we_edge = w_in_acc && w_func == FN_EDGE
                  && ECNT_W'(w_row) < ECNT_W'(MAX_EDGE_COUNT);
    end

    // Run-side writes and the shared message read address
    always_comb begin
        we_proj    = r_state == S_P_SAT;
        we_pool    = r_state == S_M_WR;
        pool_wdata = r_pool_old + {{(POOL_W-32){1'b0}}, f_sat32(w_relu)};
        we_msg     = 1'b0;
        msg_waddr  = {r_n, r_j};
        msg_wdata  = f_sat32(w_term);
        msg_raddr  = {r_n, r_k};
        case (r_state)
            S_P_SEED: begin
                we_msg = 1'b1;
            end
            S_E_WR: begin
                we_msg    = 1'b1;
                msg_waddr = {r_dst, r_j};
                msg_wdata = f_sat32(r_acc);
            end
            S_E_MRD: begin
                msg_raddr = {r_dst, r_j};
            end
            default: begin
            end
        endcase
    end

    // Shared multiplier operands
    always_comb begin
        case (r_state)
            S_P_SELF: begin
                w_ma = 33'(w_self);
                w_mb = $signed({r_val[31], r_val});
            end
            S_E_MUL: begin
                w_ma = $signed({rw_q[31], rw_q});
                w_mb = $signed({proj_q[31], proj_q});
            end
            S_M_MUL: begin
                w_ma = $signed({mw_q[31], mw_q});
                w_mb = $signed({msg_q[31], msg_q});
            end
            S_O_MUL: begin
                w_ma = $signed({r_ow[31], r_ow});
                w_mb = $signed({1'b0, w_quot});
            end
            default: begin
                w_ma = $signed({inw_q[31], inw_q});
                w_mb = $signed({feat_q[31], feat_q});
            end
        endcase
    end

    rgin_ram #(.W(32), .A(2 * HID_W)) u_inw (
        .i_clk(i_clk), .i_we(we_inw), .i_waddr({w_row[HID_W-1:0], w_col}),
        .i_wdata(w_value), .i_raddr({r_j, r_k}), .o_rdata(inw_q));
    rgin_ram #(.W(32), .A(HID_W)) u_inb (
        .i_clk(i_clk), .i_we(we_inb), .i_waddr(w_row[HID_W-1:0]),
        .i_wdata(w_value), .i_raddr(r_j), .o_rdata(inb_q));
    rgin_ram #(.W(32), .A(REL_W + 2 * HID_W)) u_rw (
        .i_clk(i_clk), .i_we(we_rw), .i_waddr({w_rel, w_row[HID_W-1:0], w_col}),
        .i_wdata(w_value), .i_raddr({r_r, r_j, r_k}), .o_rdata(rw_q));
    rgin_ram #(.W(32), .A(2 * HID_W)) u_mw (
        .i_clk(i_clk), .i_we(we_mw), .i_waddr({w_row[HID_W-1:0], w_col}),
        .i_wdata(w_value), .i_raddr({r_j, r_k}), .o_rdata(mw_q));
    rgin_ram #(.W(32), .A(HID_W)) u_mb (
        .i_clk(i_clk), .i_we(we_mb), .i_waddr(w_row[HID_W-1:0]),
        .i_wdata(w_value), .i_raddr(r_j), .o_rdata(mb_q));
    rgin_ram #(.W(32), .A(HID_W)) u_ow (
        .i_clk(i_clk), .i_we(we_ow), .i_waddr(w_row[HID_W-1:0]),
        .i_wdata(w_value), .i_raddr(r_j), .o_rdata(ow_q));
    rgin_ram #(.W(32), .A(NODE_W + HID_W)) u_feat (
        .i_clk(i_clk), .i_we(we_feat), .i_waddr({w_row[NODE_W-1:0], w_col}),
        .i_wdata(w_value), .i_raddr({r_n, r_k}), .o_rdata(feat_q));
    rgin_ram #(.W(EREC_W), .A(EDGE_W)) u_edge (
        .i_clk(i_clk), .i_we(we_edge), .i_waddr(w_row),
        .i_wdata({w_rel, w_dst, w_src}), .i_raddr(r_e), .o_rdata(edge_q));
    rgin_ram #(.W(32), .A(NODE_W + HID_W)) u_proj (
        .i_clk(i_clk), .i_we(we_proj), .i_waddr({r_n, r_j}),
        .i_wdata(f_sat32(w_relu)), .i_raddr({r_src, r_k}), .o_rdata(proj_q));
    rgin_ram #(.W(32), .A(NODE_W + HID_W)) u_msg (
        .i_clk(i_clk), .i_we(we_msg), .i_waddr(msg_waddr),
        .i_wdata(msg_wdata), .i_raddr(msg_raddr), .o_rdata(msg_q));
    rgin_ram #(.W(POOL_W), .A(HID_W)) u_pool (
        .i_clk(i_clk), .i_we(we_pool), .i_waddr(r_j),
        .i_wdata(pool_wdata), .i_raddr(r_j), .o_rdata(pool_q));

    rgin_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_O_DIV),
        .i_dividend(pool_q[DIVD_W-1:0]), .i_divisor(r_ncnt),
        .o_done(w_div_done), .o_quot(w_quot));

    // Sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
            r_eps      <= '0;
            r_obias    <= '0;
        end else begin
            r_prod <= w_ma * w_mb;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_EPS:  r_eps   <= i_cfg_data[17:0];
                    CFG_BIAS: r_obias <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_m_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_func == FN_RUN) begin
                        r_ncnt <= w_ncnt_sat;
                        r_ecnt <= w_ecnt_sat;
                        r_flag <= 1'b0;
                        r_n    <= '0;
                        r_j    <= '0;
                        if (w_ncnt_sat == '0) begin
                            r_pred   <= '0;
                            r_status <= ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_P_BIAS;
                        end
                    end
                end
                // Input projection
                S_P_BIAS: r_state <= S_P_INIT;
                S_P_INIT: begin
                    r_acc   <= ACC_W'($signed(inb_q));
                    r_k     <= '0;
                    r_state <= S_P_RD;
                end
                S_P_RD:  r_state <= S_P_MUL;
                S_P_MUL: r_state <= S_P_ACC;
                S_P_ACC: begin
                    r_acc <= r_acc + w_term;
                    r_k   <= r_k + HID_W'(1);
                    r_state <= w_k_last_f ? S_P_SAT : S_P_RD;
                end
                S_P_SAT: begin
                    r_val   <= f_sat32(w_relu);
                    r_flag  <= r_flag | f_clips(w_relu);
                    r_state <= S_P_SELF;
                end
                S_P_SELF: r_state <= S_P_SEED;
                S_P_SEED: begin
                    r_flag <= r_flag | f_clips(w_term);
                    r_j    <= r_j + HID_W'(1);
                    if (!w_j_last) begin
                        r_state <= S_P_BIAS;
                    end else if (!w_n_last) begin
                        r_n     <= r_n + NODE_W'(1);
                        r_state <= S_P_BIAS;
                    end else begin
                        r_n <= '0;
                        r_e <= '0;
                        r_r <= '0;
                        r_state <= (r_ecnt == '0) ? S_M_BIAS : S_E_RD;
                    end
                end
                // Edge messages, relation by relation
                S_E_RD: r_state <= S_E_CHK;
                S_E_CHK: begin
                    r_src <= edge_q[NODE_W-1:0];
                    r_dst <= edge_q[2*NODE_W-1:NODE_W];
                    r_j   <= '0;
                    if (w_edge_ok) begin
                        r_state <= S_E_MRD;
                    end else begin
                        r_e <= w_e_last ? '0 : r_e + EDGE_W'(1);
                        if (w_e_last && w_r_last) begin
                            r_state <= S_M_BIAS;
                        end else begin
                            r_r     <= w_e_last ? r_r + REL_W'(1) : r_r;
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_E_MRD: r_state <= S_E_MINIT;
                S_E_MINIT: begin
                    r_acc   <= ACC_W'($signed(msg_q));
                    r_k     <= '0;
                    r_state <= S_E_WRD;
                end
                S_E_WRD: r_state <= S_E_MUL;
                S_E_MUL: r_state <= S_E_ACC;
                S_E_ACC: begin
                    r_acc <= r_acc + w_term;
                    r_k   <= r_k + HID_W'(1);
                    r_state <= w_k_last_h ? S_E_WR : S_E_WRD;
                end
                S_E_WR: begin
                    r_flag <= r_flag | f_clips(r_acc);
                    r_j    <= r_j + HID_W'(1);
                    if (!w_j_last) begin
                        r_state <= S_E_MRD;
                    end else begin
                        r_e <= w_e_last ? '0 : r_e + EDGE_W'(1);
                        if (w_e_last && w_r_last) begin
                            r_state <= S_M_BIAS;
                        end else begin
                            r_r     <= w_e_last ? r_r + REL_W'(1) : r_r;
                            r_state <= S_E_RD;
                        end
                    end
                end
                // MLP and pooled sum
                S_M_BIAS: r_state <= S_M_INIT;
                S_M_INIT: begin
                    r_acc      <= ACC_W'($signed(mb_q));
                    r_pool_old <= (r_n == '0) ? '0 : pool_q;
                    r_k        <= '0;
                    r_state    <= S_M_RD;
                end
                S_M_RD:  r_state <= S_M_MUL;
                S_M_MUL: r_state <= S_M_ACC;
                S_M_ACC: begin
                    r_acc <= r_acc + w_term;
                    r_k   <= r_k + HID_W'(1);
                    r_state <= w_k_last_h ? S_M_WR : S_M_RD;
                end
                S_M_WR: begin
                    r_flag <= r_flag | f_clips(w_relu);
                    r_j    <= r_j + HID_W'(1);
                    if (!w_j_last) begin
                        r_state <= S_M_BIAS;
                    end else if (!w_n_last) begin
                        r_n     <= r_n + NODE_W'(1);
                        r_state <= S_M_BIAS;
                    end else begin
                        r_acc   <= ACC_W'($signed(r_obias));
                        r_state <= S_O_RD;
                    end
                end
                // Mean and output dot product
                S_O_RD: r_state <= S_O_DIV;
                S_O_DIV: begin
                    r_ow    <= ow_q;
                    r_state <= S_O_WAIT;
                end
                S_O_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_O_MUL;
                    end
                end
                S_O_MUL: r_state <= S_O_ACC;
                S_O_ACC: begin
                    r_acc <= r_acc + w_term;
                    r_j   <= r_j + HID_W'(1);
                    r_state <= w_j_last ? S_O_FIN : S_O_RD;
                end
                S_O_FIN: begin
                    r_pred   <= f_sat32(r_acc);
                    r_status <= (r_flag || f_clips(r_acc)) ? ST_SAT : ST_OK;
                    r_state  <= S_OUT;
                end
                // Hand the result to the output register
                S_OUT: begin
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= r_pred;
                        r_m_tuser  <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign o_cfg_ready   = 1'b1;

endmodule

/* rtl/rgin_chk.sv */
// Port-level checker of the graph inference block, with its bind.
`include "relational_gin_graph_inference_assert.svh"

module rgin_chk
    import rgin_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Hold a stalled result beat
    `RGIN_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Status is one of the three defined codes
    `RGIN_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_SAT)
    // Empty graph yields a zero prediction
    `RGIN_ASSERT_NOW(a_empty_zero, m_axis_tvalid && m_axis_tuser == ST_EMPTY, m_axis_tdata == 32'd0)
    // Stall input after a run beat
    `RGIN_ASSERT_NXT(a_run_stalls, s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_RUN, !s_axis_tready)

endmodule

bind relational_gin_graph_inference rgin_chk u_rgin_chk (.*);
